FILE: rtl/core/deq_pkg.sv
// Shared constants, command and status codes, and item types for the deque.
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DEPTH  = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 6;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_out;
        logic [STAT_W-1:0]        status;
        logic [OCC_W-1:0]         occupancy;
        logic                     last;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic              wr_front;
        logic              wr_back;
        logic              rd_front;
        logic              rd_back;
        logic              clear;
        logic              dump_first;
        logic              dump_next;
        logic              load_direct;
        logic              load_read;
        logic [STAT_W-1:0] stat;
        logic              last;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
        logic dump_last;
    } dp_stat_t;

endpackage

FILE: rtl/core/double_ended_queue_unit.sv
// Push, clear, empty pop or dump, and unused codes: result is registered and shown in the cycle after accept.
// Pop and every dump entry: read into the RAM's read register, then loaded into the result register.
// One item in flight at a time, with the single registered-read entry RAM: no new request
// is taken until the previous result, or a dump's last entry, has been taken.
// Reset (rst_n, async, active low) empties the queue; entry RAM contents are left as is.
`timescale 1ns / 1ps

module double_ended_queue_unit import deq_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .command   (req.command),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    deq_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (dp_cmd),
        .stat  (dp_stat),
        .rsp   (rsp)
    );

endmodule

FILE: rtl/core/deq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/deq_dp.sv
// Deque datapath: front ring pointer, entry count, dump index, entry RAM, result register.
`timescale 1ns / 1ps

module deq_dp import deq_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  req_t     req,
    input  dp_cmd_t  cmd,
    output dp_stat_t stat,
    output rsp_t     rsp
);

    logic [ADDR_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;

    logic signed [DATA_W-1:0] value_reg;
    logic [STAT_W-1:0]        status_reg;
    logic                     last_reg;

    logic [ADDR_W-1:0] front_dec;
    logic [ADDR_W-1:0] front_inc;
    logic [ADDR_W-1:0] idx_inc;
    logic [ADDR_W-1:0] addr;
    logic              ram_we;
    logic              ram_re;
    logic [DATA_W-1:0] ram_rdata;

    // (front + offset) mod DEPTH; the sum always stays below 2 * DEPTH
    function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] base,
                                                  input logic [CNT_W-1:0]  offset);
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + (ADDR_W+1)'(offset);
        if (sum >= (ADDR_W+1)'(DEPTH))
        begin
            sum = sum - (ADDR_W+1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    assign front_dec = (front_reg == '0) ? ADDR_W'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = slot_of(front_reg, CNT_W'(1));
    assign idx_inc   = idx_reg + 1'b1;

    assign stat.full      = (count_reg == CNT_W'(DEPTH));
    assign stat.empty     = (count_reg == '0);
    assign stat.dump_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    always_comb
    begin
        if (cmd.wr_front)
        begin
            addr = front_dec;
        end
        else if (cmd.wr_back)
        begin
            addr = slot_of(front_reg, count_reg);
        end
        else if (cmd.rd_back)
        begin
            addr = slot_of(front_reg, count_reg - 1'b1);
        end
        else if (cmd.dump_next)
        begin
            addr = slot_of(front_reg, CNT_W'(idx_inc));
        end
        else
        begin
            addr = front_reg;
        end
    end

    assign ram_we = cmd.wr_front | cmd.wr_back;
    assign ram_re = cmd.rd_front | cmd.rd_back | cmd.dump_first | cmd.dump_next;

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr),
        .wdata (req.value),
        .re    (ram_re),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        if (cmd.wr_front)
        begin
            front_next = front_dec;
            count_next = count_reg + 1'b1;
        end
        if (cmd.wr_back)
        begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.rd_front)
        begin
            front_next = front_inc;
            count_next = count_reg - 1'b1;
        end
        if (cmd.rd_back)
        begin
            count_next = count_reg - 1'b1;
        end
        if (cmd.clear)
        begin
            front_next = '0;
            count_next = '0;
        end
        if (cmd.dump_first)
        begin
            idx_next = '0;
        end
        if (cmd.dump_next)
        begin
            idx_next = idx_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_direct)
        begin
            value_reg  <= '0;
            status_reg <= cmd.stat;
            last_reg   <= 1'b1;
        end
        else if (cmd.load_read)
        begin
            value_reg  <= ram_rdata;
            status_reg <= STAT_OK;
            last_reg   <= cmd.last;
        end
    end

    // occupancy comes straight from the count, which holds while a result waits
    assign rsp.value_out = value_reg;
    assign rsp.status    = status_reg;
    assign rsp.occupancy = OCC_W'(count_reg);
    assign rsp.last      = last_reg;

endmodule

FILE: rtl/core/deq_ctrl.sv
// Deque controller: command decode and sequencing of reads, results and dumps.
`timescale 1ns / 1ps

module deq_ctrl import deq_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  logic [CMD_W-1:0] command,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    input  dp_stat_t         stat,
    output dp_cmd_t          cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WAIT = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       dump_reg, dump_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        dump_next  = dump_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (command) inside
                        CMD_PUSH_FRONT, CMD_PUSH_BACK:
                        begin
                            cmd.load_direct = 1'b1;
                            state_next      = S_OUT;
                            if (stat.full)
                            begin
                                cmd.stat = STAT_FULL;
                            end
                            else
                            begin
                                cmd.stat     = STAT_OK;
                                cmd.wr_front = (command == CMD_PUSH_FRONT);
                                cmd.wr_back  = (command == CMD_PUSH_BACK);
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load_direct = 1'b1;
                                cmd.stat        = STAT_EMPTY;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                cmd.rd_front = (command == CMD_POP_FRONT);
                                cmd.rd_back  = (command == CMD_POP_BACK);
                                state_next   = S_WAIT;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            cmd.load_direct = 1'b1;
                            state_next      = S_OUT;
                            if (stat.empty)
                            begin
                                cmd.stat = STAT_EMPTY;
                            end
                            else
                            begin
                                cmd.stat  = STAT_OK;
                                cmd.clear = 1'b1;
                            end
                        end
                        CMD_DUMP:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load_direct = 1'b1;
                                cmd.stat        = STAT_EMPTY;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                cmd.dump_first = 1'b1;
                                dump_next      = 1'b1;
                                state_next     = S_WAIT;
                            end
                        end
                        default:
                        begin
                            cmd.load_direct = 1'b1;
                            cmd.stat        = STAT_OK;
                            state_next      = S_OUT;
                        end
                    endcase
                end
            end
            S_WAIT:
            begin
                // RAM data is valid now
                cmd.load_read = 1'b1;
                cmd.last      = dump_reg ? stat.dump_last : 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (!rsp_stall)
                begin
                    if (dump_reg && !stat.dump_last)
                    begin
                        cmd.dump_next = 1'b1;
                        state_next    = S_WAIT;
                    end
                    else
                    begin
                        dump_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                dump_next  = 1'b0;
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dump_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dump_reg  <= dump_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = (state_reg == S_OUT);

endmodule

FILE: rtl/core/deq_checker.sv
// Port-level checks for the deque, bound to the top level.
`timescale 1ns / 1ps

module deq_checker import deq_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // held result item stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result item changed");

    // one item in flight: no request taken while a result is shown
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |-> !rsp_valid)
        else $error("request accepted while result pending");

    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STAT_FULL |-> rsp.value_out == '0 && rsp.last)
        else $error("bad full result");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STAT_EMPTY
            |-> rsp.occupancy == '0 && rsp.value_out == '0 && rsp.last)
        else $error("bad empty result");

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (.*);

FILE: tb/tb.sv
// Self-checking testbench for double_ended_queue_unit.
`timescale 1ns / 1ps

module tb import deq_pkg::*; ();

    localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

    localparam int PH_FILL  = 0;
    localparam int PH_MIXED = 1;
    localparam int PH_DRAIN = 2;

    localparam int STALL_NONE = 0;
    localparam int STALL_SOME = 1;
    localparam int STALL_MOST = 2;

    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TAIL_CYCLES  = 20;

    typedef struct {
        req_t r;
        bit   drain_wait;   // not sent: sender holds off until all results are in
    } pending_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    pending_t pending[$];
    rsp_t     expected[$];

    // predictor state
    logic signed [DATA_W-1:0] ring[DEPTH];
    int head;
    int held;

    int errors = 0;
    int cycles = 0;
    int burst_left;
    int gap_left;
    int stall_mode;
    int mode_left;

    double_ended_queue_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void add_result(logic signed [DATA_W-1:0] v, logic [STAT_W-1:0] st,
                                       logic lst);
        rsp_t e;
        e.value_out = v;
        e.status    = st;
        e.occupancy = held[OCC_W-1:0];
        e.last      = lst;
        expected.push_back(e);
    endfunction

    function automatic void predict_deque(req_t r);
        logic signed [DATA_W-1:0] v;
        case (r.command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (held >= DEPTH)
                begin
                    add_result('0, STAT_FULL, 1'b1);
                end
                else
                begin
                    if (r.command == CMD_PUSH_FRONT)
                    begin
                        head = (head + DEPTH - 1) % DEPTH;
                        ring[head] = r.value;
                    end
                    else
                    begin
                        ring[(head + held) % DEPTH] = r.value;
                    end
                    held++;
                    add_result('0, STAT_OK, 1'b1);
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (held == 0)
                begin
                    add_result('0, STAT_EMPTY, 1'b1);
                end
                else
                begin
                    if (r.command == CMD_POP_FRONT)
                    begin
                        v = ring[head];
                        head = (head + 1) % DEPTH;
                    end
                    else
                    begin
                        v = ring[(head + held - 1) % DEPTH];
                    end
                    held--;
                    add_result(v, STAT_OK, 1'b1);
                end
            end
            CMD_CLEAR:
            begin
                if (held == 0)
                begin
                    add_result('0, STAT_EMPTY, 1'b1);
                end
                else
                begin
                    held = 0;
                    head = 0;
                    add_result('0, STAT_OK, 1'b1);
                end
            end
            CMD_DUMP:
            begin
                if (held == 0)
                    add_result('0, STAT_EMPTY, 1'b1);
                else
                    for (int i = 0; i < held; i++)
                        add_result(ring[(head + i) % DEPTH], STAT_OK, i == held - 1);
            end
            default:
            begin
                add_result('0, STAT_OK, 1'b1);
            end
        endcase
    endfunction

    task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    function automatic logic signed [DATA_W-1:0] rand_value();
        if ($urandom_range(0, 7) != 0)
            return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0;
            default: return -32'sd1;
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(int phase);
        int r;
        r = $urandom_range(0, 99);
        if (phase == PH_FILL && r < 85)
            return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        if (phase == PH_DRAIN && r < 85)
            return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
        r = $urandom_range(0, 99);
        if (r < 30)
            return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        if (r < 60)
            return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
        if (r < 66)
            return CMD_CLEAR;
        if (r < 76)
            return CMD_DUMP;
        if (r < 80)
            return $urandom_range(0, 1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
        return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    endfunction

    function automatic void add_item(logic [CMD_W-1:0] c, logic signed [DATA_W-1:0] v);
        pending_t p;
        p.r.command  = c;
        p.r.value    = v;
        p.drain_wait = 1'b0;
        pending.push_back(p);
    endfunction

    function automatic void add_drain();
        pending_t p;
        p.r          = '0;
        p.drain_wait = 1'b1;
        pending.push_back(p);
    endfunction

    // sender: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        bit fire;
        bit go;
        if (!rst_n)
        begin
            req_valid  <= 1'b0;
            req        <= '0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            fire = req_valid && !req_stall;
            go   = 1'b0;
            if (fire)
                pending.pop_front();
            if (fire || !req_valid)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending.size() > 0 && pending[0].drain_wait)
                begin
                    if (!req_valid && expected.size() == 0)
                        pending.pop_front();
                end
                else if (pending.size() > 0)
                begin
                    go = 1'b1;
                end
                if (go)
                begin
                    req <= pending[0].r;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                req_valid <= go;
            end
        end
    end

    // predicts on accepted requests, checks accepted results, drives rsp_stall
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            head       = 0;
            held       = 0;
            stall_mode = STALL_NONE;
            mode_left  = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                predict_deque(req);
            if (rsp_valid && !rsp_stall)
            begin
                if (expected.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual %p", $time, rsp);
                    errors++;
                end
                else
                begin
                    want = expected.pop_front();
                    check_field("value_out", want.value_out, rsp.value_out);
                    check_field("status", DATA_W'(want.status), DATA_W'(rsp.status));
                    check_field("occupancy", DATA_W'(want.occupancy),
                                DATA_W'(rsp.occupancy));
                    check_field("last", DATA_W'(want.last), DATA_W'(rsp.last));
                end
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(STALL_NONE, STALL_MOST);
                mode_left  = $urandom_range(16, 160);
            end
            else
            begin
                mode_left--;
            end
            case (stall_mode)
                STALL_NONE: rsp_stall <= 1'b0;
                STALL_SOME: rsp_stall <= ($urandom_range(0, 3) == 0);
                default:    rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("double_ended_queue_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        int phase_list[4];
        int n;
        int span;
        int k;

        // directed: empty cases, unused codes, extreme values, both ends
        add_item(CMD_POP_FRONT, 32'sh1234_5678);
        add_item(CMD_POP_BACK, 32'sh0);
        add_item(CMD_CLEAR, 32'sh0);
        add_item(CMD_DUMP, 32'sh0);
        add_item(CMD_UNUSED_6, -32'sd1);
        add_item(CMD_UNUSED_7, 32'sh7fff_ffff);
        add_item(CMD_PUSH_FRONT, 32'sh8000_0000);
        add_item(CMD_PUSH_BACK, 32'sh7fff_ffff);
        add_item(CMD_PUSH_FRONT, 32'sh0);
        add_item(CMD_PUSH_BACK, -32'sd1);
        add_item(CMD_UNUSED_6, 32'sh0);
        add_item(CMD_DUMP, 32'sh0);
        add_item(CMD_POP_FRONT, 32'sh0);
        add_item(CMD_POP_BACK, 32'sh0);
        add_item(CMD_PUSH_BACK, 32'sh5555_5555);
        add_item(CMD_PUSH_FRONT, 32'shaaaa_aaaa);
        add_item(CMD_DUMP, 32'sh0);
        add_item(CMD_CLEAR, 32'sh0);
        add_item(CMD_POP_BACK, 32'sh0);
        add_item(CMD_DUMP, 32'sh0);
        add_drain();

        // fill past full, dump a full queue, then drain past empty
        for (k = 0; k < DEPTH + 4; k++)
            add_item($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, rand_value());
        add_item(CMD_DUMP, rand_value());
        for (k = 0; k < DEPTH + 2; k++)
            add_item($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK, rand_value());
        add_drain();

        phase_list[0] = PH_FILL;
        phase_list[1] = PH_MIXED;
        phase_list[2] = PH_DRAIN;
        phase_list[3] = PH_MIXED;
        n = 2 * DEPTH + 7;
        k = 0;
        while (n < RANDOM_ITEMS)
        begin
            span = $urandom_range(20, 50);
            for (int j = 0; j < span; j++)
                add_item(pick_command(phase_list[k % 4]), rand_value());
            n += span;
            k++;
            if ($urandom_range(0, 3) == 0)
                add_drain();
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending.size() != 0 || req_valid || expected.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0 && expected.size() == 0)
            $display("double_ended_queue_unit regression: pass");
        else
            $display("double_ended_queue_unit regression: fail");
        $finish;
    end

endmodule
